FILE: rtl/bcpe_pkg.sv
// ----------------------------------------------------------------------------
// bcpe_pkg - shared types and constants for the Bezier point evaluator
// Field structs, controller states, command/status groups, binomial table.
// ----------------------------------------------------------------------------
`default_nettype none

package bcpe_pkg;

  localparam int MAX_POINTS = 16;
  localparam int COORD_BITS = 12;

  localparam int ADDR_W    = $clog2(MAX_POINTS);
  localparam int COEF_W    = MAX_POINTS - 1;
  localparam int TAB_W     = $clog2(MAX_POINTS * MAX_POINTS);
  localparam int U_BITS    = 16;
  localparam int P_W       = U_BITS + 1;
  localparam int W_W       = COEF_W + P_W;
  localparam int WP_W      = W_W + COORD_BITS;
  localparam int SUM_W     = WP_W;
  localparam int DIV_CNT_W = $clog2(U_BITS);

  localparam int PC_W       = 5;
  localparam int SD_W       = 11;
  localparam int STEP_W     = 11;
  localparam int IDX_W      = 4;
  localparam int FCOORD_W   = 12;
  localparam int OUT_W      = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 11;

  localparam logic [PC_W-1:0] PC_RESET = 5'd4;
  localparam logic [SD_W-1:0] SD_RESET = 11'd1000;
  localparam logic [P_W-1:0]  ONE_Q16  = 17'h10000;
  localparam int              OUT_MAX  = 65535;

  localparam logic [CFG_IDX_W-1:0] CFG_POINT_COUNT  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SUBDIVISIONS = 1'd1;

  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_EVAL = 1'b1;

  typedef struct packed {
    logic                action;
    logic [IDX_W-1:0]    point_index;
    logic [FCOORD_W-1:0] point_x;
    logic [FCOORD_W-1:0] point_y;
    logic [STEP_W-1:0]   step_index;
  } bcpe_in_t;

  typedef struct packed {
    logic [OUT_W-1:0] curve_x;
    logic [OUT_W-1:0] curve_y;
  } bcpe_out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SETUP,
    ST_LAST,
    ST_DIV,
    ST_UINIT,
    ST_VMUL,
    ST_WEIGHT,
    ST_PROD,
    ST_ACC,
    ST_UMUL,
    ST_FINISH
  } bcpe_state_t;

  typedef struct packed {
    logic capture;
    logic load;
    logic rd_last;
    logic div_step;
    logic pw_init;
    logic pw_v;
    logic pw_u;
    logic weight;
    logic prod;
    logic acc;
    logic next_k;
    logic out_sum;
    logic out_last;
  } bcpe_cmd_t;

  typedef struct packed {
    logic last_step;
    logic div_done;
    logic v_done;
    logic k_last;
    logic out_free;
  } bcpe_sts_t;

  typedef logic [MAX_POINTS*MAX_POINTS-1:0][COEF_W-1:0] binom_tab_t;

  function automatic binom_tab_t make_binom();
    binom_tab_t tab;
    longint     row [MAX_POINTS];
    tab = '0;
    for (int i = 0; i < MAX_POINTS; i++) begin
      row[i] = 0;
    end
    row[0] = 1;
    for (int i = 0; i < MAX_POINTS; i++) begin
      for (int k = i; k > 0; k--) begin
        row[k] = row[k] + row[k-1];
      end
      for (int k = 0; k <= i; k++) begin
        tab[i*MAX_POINTS + k] = COEF_W'(row[k]);
      end
    end
    return tab;
  endfunction

  localparam binom_tab_t BINOM = make_binom();

endpackage

`default_nettype wire

FILE: rtl/bcpe_ram.sv
// ----------------------------------------------------------------------------
// bcpe_ram - generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bcpe_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: rtl/bcpe_ctrl.sv
// ----------------------------------------------------------------------------
// bcpe_ctrl - sequencer for the Bezier point evaluator
// Walks divide, power products, weighting and accumulation per control point.
// ----------------------------------------------------------------------------
`default_nettype none

module bcpe_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  input  wire logic                in_action,
  output logic                     in_ready,
  output bcpe_pkg::bcpe_cmd_t      cmd,
  input  wire bcpe_pkg::bcpe_sts_t sts
);

  import bcpe_pkg::*;

  bcpe_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_action == ACT_EVAL) begin
            cmd.capture = 1'b1;
            state_next  = ST_SETUP;
          end else begin
            cmd.load = 1'b1;
          end
        end
      end
      ST_SETUP: begin
        cmd.rd_last = 1'b1;
        state_next  = sts.last_step ? ST_LAST : ST_DIV;
      end
      ST_LAST: begin
        cmd.rd_last = 1'b1;
        if (sts.out_free) begin
          cmd.out_last = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) begin
          state_next = ST_UINIT;
        end
      end
      ST_UINIT: begin
        cmd.pw_init = 1'b1;
        state_next  = ST_VMUL;
      end
      ST_VMUL: begin
        if (sts.v_done) begin
          state_next = ST_WEIGHT;
        end else begin
          cmd.pw_v = 1'b1;
        end
      end
      ST_WEIGHT: begin
        cmd.weight = 1'b1;
        state_next = ST_PROD;
      end
      ST_PROD: begin
        cmd.prod   = 1'b1;
        state_next = ST_ACC;
      end
      ST_ACC: begin
        cmd.acc = 1'b1;
        if (sts.k_last) begin
          state_next = ST_FINISH;
        end else begin
          cmd.next_k = 1'b1;
          state_next = ST_UMUL;
        end
      end
      ST_UMUL: begin
        cmd.pw_u   = 1'b1;
        state_next = ST_VMUL;
      end
      ST_FINISH: begin
        if (sts.out_free) begin
          cmd.out_sum = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/bcpe_dpath.sv
// ----------------------------------------------------------------------------
// bcpe_dpath - datapath of the Bezier point evaluator
// Config registers, point store, u divider, Q1.16 power chain, weighted sums.
// ----------------------------------------------------------------------------
`default_nettype none

module bcpe_dpath (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_we,
  input  wire logic [bcpe_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [bcpe_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  wire bcpe_pkg::bcpe_in_t                  in_data,
  input  wire bcpe_pkg::bcpe_cmd_t                 cmd,
  output bcpe_pkg::bcpe_sts_t                      sts,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output bcpe_pkg::bcpe_out_t                      out_data
);

  import bcpe_pkg::*;

  function automatic logic [OUT_W-1:0] sat16(input logic [SUM_W-1:0] val);
    if (val > SUM_W'(OUT_MAX)) begin
      return OUT_W'(OUT_MAX);
    end
    return OUT_W'(val);
  endfunction

  logic [PC_W-1:0]      point_count;
  logic [SD_W-1:0]      subdivisions;
  logic [ADDR_W-1:0]    n_r;
  logic [SD_W-1:0]      m_r;
  logic                 last_r;
  logic [SD_W-1:0]      rem;
  logic [U_BITS-1:0]    nlo;
  logic [U_BITS-1:0]    quo;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic [P_W-1:0]       v_r;
  logic [P_W-1:0]       ukp;
  logic [P_W-1:0]       p;
  logic [ADDR_W-1:0]    k;
  logic [ADDR_W-1:0]    j;
  logic [W_W-1:0]       w;
  logic [WP_W-1:0]      wx;
  logic [WP_W-1:0]      wy;
  logic [SUM_W-1:0]     sx;
  logic [SUM_W-1:0]     sy;

  logic [ADDR_W-1:0]       n_c;
  logic [SD_W-1:0]         m_c;
  logic [STEP_W-1:0]       step_c;
  logic [SD_W:0]           rem_sh;
  logic                    rem_ge;
  logic [P_W-1:0]          mul_a;
  logic [P_W-1:0]          mul_b;
  logic [2*P_W-1:0]        mul_full;
  logic [P_W-1:0]          mul_res;
  logic [COEF_W-1:0]       coef;
  logic                    ram_we;
  logic [2*COORD_BITS-1:0] ram_wdata;
  logic [ADDR_W-1:0]       ram_raddr;
  logic [2*COORD_BITS-1:0] rd_data;
  logic [COORD_BITS-1:0]   rd_x;
  logic [COORD_BITS-1:0]   rd_y;
  logic [SUM_W-1:0]        sum_x_rnd;
  logic [SUM_W-1:0]        sum_y_rnd;

  // Configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      point_count  <= PC_RESET;
      subdivisions <= SD_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_POINT_COUNT:  point_count  <= cfg_wdata[PC_W-1:0];
        CFG_SUBDIVISIONS: subdivisions <= cfg_wdata[SD_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Clamped operands for a new evaluation
  always_comb begin
    if (point_count < PC_W'(2)) begin
      n_c = ADDR_W'(1);
    end else if (32'(point_count) > MAX_POINTS) begin
      n_c = ADDR_W'(MAX_POINTS - 1);
    end else begin
      n_c = ADDR_W'(point_count - PC_W'(1));
    end
    m_c    = (subdivisions == '0) ? SD_W'(1) : subdivisions;
    step_c = (in_data.step_index > m_c) ? m_c : in_data.step_index;
  end

  // Point store
  assign ram_we    = cmd.load && (32'(in_data.point_index) < MAX_POINTS);
  assign ram_wdata = {COORD_BITS'(in_data.point_y), COORD_BITS'(in_data.point_x)};
  assign ram_raddr = cmd.rd_last ? n_r : k;
  assign rd_x      = rd_data[COORD_BITS-1:0];
  assign rd_y      = rd_data[2*COORD_BITS-1:COORD_BITS];

  bcpe_ram #(
    .WIDTH (2*COORD_BITS),
    .DEPTH (MAX_POINTS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ADDR_W'(in_data.point_index)),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (rd_data)
  );

  // Restoring divider: u = (step*2^16 + m/2) / m, one quotient bit per cycle
  assign rem_sh = {rem, nlo[U_BITS-1]};
  assign rem_ge = (rem_sh >= {1'b0, m_r});

  // Shared Q1.16 multiplier with round half up
  assign mul_a    = cmd.pw_u ? ukp : p;
  assign mul_b    = cmd.pw_u ? {1'b0, quo} : v_r;
  assign mul_full = (2*P_W)'(mul_a) * (2*P_W)'(mul_b);
  assign mul_res  = P_W'((mul_full + (2*P_W)'(32768)) >> U_BITS);

  assign coef = BINOM[TAB_W'(32'(n_r) * MAX_POINTS + 32'(k))];

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      n_r     <= n_c;
      m_r     <= m_c;
      last_r  <= (step_c == m_c);
      rem     <= step_c;
      nlo     <= U_BITS'(m_c >> 1);
      quo     <= '0;
      div_cnt <= '0;
    end
    if (cmd.div_step) begin
      rem     <= rem_ge ? SD_W'(rem_sh - {1'b0, m_r}) : rem_sh[SD_W-1:0];
      quo     <= {quo[U_BITS-2:0], rem_ge};
      nlo     <= {nlo[U_BITS-2:0], 1'b0};
      div_cnt <= div_cnt + DIV_CNT_W'(1);
    end
    if (cmd.pw_init) begin
      v_r <= ONE_Q16 - {1'b0, quo};
      ukp <= ONE_Q16;
      p   <= ONE_Q16;
      k   <= '0;
      j   <= '0;
      sx  <= '0;
      sy  <= '0;
    end
    if (cmd.pw_v) begin
      p <= mul_res;
      j <= j + ADDR_W'(1);
    end
    if (cmd.pw_u) begin
      ukp <= mul_res;
      p   <= mul_res;
    end
    if (cmd.weight) begin
      w <= W_W'(coef) * W_W'(p);
    end
    if (cmd.prod) begin
      wx <= WP_W'(w) * WP_W'(rd_x);
      wy <= WP_W'(w) * WP_W'(rd_y);
    end
    if (cmd.acc) begin
      sx <= sx + SUM_W'(wx);
      sy <= sy + SUM_W'(wy);
    end
    if (cmd.next_k) begin
      k <= k + ADDR_W'(1);
      j <= k + ADDR_W'(1);
    end
  end

  assign sum_x_rnd = (sx + SUM_W'(2048)) >> 12;
  assign sum_y_rnd = (sy + SUM_W'(2048)) >> 12;

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_sum || cmd.out_last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_sum) begin
      out_data.curve_x <= sat16(sum_x_rnd);
      out_data.curve_y <= sat16(sum_y_rnd);
    end else if (cmd.out_last) begin
      out_data.curve_x <= sat16(SUM_W'({rd_x, 4'b0000}));
      out_data.curve_y <= sat16(SUM_W'({rd_y, 4'b0000}));
    end
  end

  assign sts.last_step = last_r;
  assign sts.div_done  = (div_cnt == DIV_CNT_W'(U_BITS - 1));
  assign sts.v_done    = (j == n_r);
  assign sts.k_last    = (k == n_r);
  assign sts.out_free  = !out_valid || out_ready;

endmodule

`default_nettype wire

FILE: rtl/bezier_curve_point_eval.sv
// ----------------------------------------------------------------------------
// bezier_curve_point_eval - Bernstein-form Bezier curve point evaluator
// Control points are loaded into a store; evaluate items return one point.
//
//   channel  dir  handshake                payload
//   in       in   in_valid / in_ready      bcpe_in_t  (load or evaluate)
//   out      out  out_valid / out_ready    bcpe_out_t (curve point, Q12.4)
//   cfg      in   cfg_we                   cfg_index, cfg_wdata
//
// A load item is written to the store and leaves the block idle. An evaluate
// item at the last step outputs the last point; any other runs the u divider
// and the per-point chain of Q1.16 products on one shared multiplier. One item
// is in work at a time.
// Reset restores config defaults and clears out_valid; the point store is
// not cleared. A stalled output holds its item while the next item is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module bezier_curve_point_eval (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire bcpe_pkg::bcpe_in_t                  in_data,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output bcpe_pkg::bcpe_out_t                      out_data,
  input  wire logic                                cfg_we,
  input  wire logic [bcpe_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [bcpe_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  import bcpe_pkg::*;

  bcpe_cmd_t cmd;
  bcpe_sts_t sts;

  bcpe_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_action (in_data.action),
    .in_ready  (in_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  bcpe_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

`ifndef ASSERT_OFF
  a_eval_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && (in_data.action == ACT_EVAL)) |=> !in_ready)
    else $error("evaluate item did not take the block busy");

  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && (in_data.action == ACT_LOAD)) |=> in_ready)
    else $error("load item left the block busy");

  a_reset_idle: assert property (@(posedge clk)
    $fell(rst) |-> (in_ready && !out_valid))
    else $error("block not idle after reset");
`endif

endmodule

`default_nettype wire

FILE: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench - Bezier curve point evaluator check
// Loads control points and evaluates curve points over many point counts and
// step counts. A fixed-point Bernstein predictor computes most curve points.
// Results are compared in order, under random gaps, stalls and a long hold.
// ----------------------------------------------------------------------------
module testbench;
  import bcpe_pkg::*;

  localparam int DRAIN_CYCLES = 260;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS = 100;
  localparam int HOLD_ITEMS = 24;

  typedef enum bit [1:0] {ROW_ITEM, ROW_ITEM_FIXED, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t             kind;
    bcpe_in_t              item;
    bcpe_out_t             result;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] reg_val;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  bcpe_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  bcpe_out_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // predictor state
  logic [COORD_BITS-1:0] store_x [MAX_POINTS];
  logic [COORD_BITS-1:0] store_y [MAX_POINTS];
  logic [PC_W-1:0] cfg_points = PC_RESET;
  logic [SD_W-1:0] cfg_steps = SD_RESET;

  bcpe_out_t pending_points [$];
  bcpe_out_t due_point;
  plan_row_t plan [$];

  int mismatches = 0;
  int points_checked = 0;
  int items_sent = 0;
  int settings_used = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_req = 0;
  int hold_left = 0;

  always #2 clk = ~clk;

  bezier_curve_point_eval u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  function automatic longint unsigned clip16(longint unsigned a);
    return (a > OUT_MAX) ? longint'(OUT_MAX) : a;
  endfunction

  function automatic longint unsigned q16_mul(longint unsigned a, longint unsigned b);
    return (a * b + 64'd32768) >> 16;
  endfunction

  function automatic bcpe_out_t curve_point(logic [STEP_W-1:0] step_in);
    int cnt, m, n, s;
    longint unsigned u, v, coef, p, w, sx, sy;
    bcpe_out_t r;
    cnt = cfg_points;
    if (cnt < 2) cnt = 2;
    if (cnt > MAX_POINTS) cnt = MAX_POINTS;
    m = (cfg_steps == 0) ? 1 : int'(cfg_steps);
    s = step_in;
    if (s > m) s = m;
    n = cnt - 1;
    if (s == m) begin
      r.curve_x = OUT_W'(clip16(64'(store_x[n]) << 4));
      r.curve_y = OUT_W'(clip16(64'(store_y[n]) << 4));
      return r;
    end
    u = (64'(s) * 64'd65536 + 64'(m >> 1)) / 64'(m);
    v = 64'd65536 - u;
    coef = 1;
    sx = 0;
    sy = 0;
    for (int k = 0; k <= n; k++) begin
      p = 64'd65536;
      for (int j = 0; j < k; j++) p = q16_mul(p, u);
      for (int j = k; j < n; j++) p = q16_mul(p, v);
      w = coef * p;
      sx += w * 64'(store_x[k]);
      sy += w * 64'(store_y[k]);
      coef = coef * 64'(n - k) / 64'(k + 1);
    end
    r.curve_x = OUT_W'(clip16((sx + 64'd2048) >> 12));
    r.curve_y = OUT_W'(clip16((sy + 64'd2048) >> 12));
    return r;
  endfunction

  function automatic plan_row_t ld(int idx, int x, int y);
    plan_row_t r;
    r = '{kind: ROW_ITEM, item: '0, result: '0, reg_idx: '0, reg_val: '0};
    r.item.action = ACT_LOAD;
    r.item.point_index = IDX_W'(idx);
    r.item.point_x = FCOORD_W'(x);
    r.item.point_y = FCOORD_W'(y);
    return r;
  endfunction

  function automatic plan_row_t ev(int step);
    plan_row_t r;
    r = '{kind: ROW_ITEM, item: '0, result: '0, reg_idx: '0, reg_val: '0};
    r.item.action = ACT_EVAL;
    r.item.step_index = STEP_W'(step);
    return r;
  endfunction

  function automatic plan_row_t ev_fix(int step, int x, int y);
    plan_row_t r;
    r = ev(step);
    r.kind = ROW_ITEM_FIXED;
    r.result.curve_x = OUT_W'(x);
    r.result.curve_y = OUT_W'(y);
    return r;
  endfunction

  function automatic plan_row_t cf(logic [CFG_IDX_W-1:0] idx, int val);
    plan_row_t r;
    r = '{kind: ROW_CFG, item: '0, result: '0, reg_idx: idx, reg_val: CFG_DATA_W'(val)};
    return r;
  endfunction

  function automatic bcpe_in_t random_item();
    bcpe_in_t it;
    int pick;
    it.action = ($urandom_range(99) < 75) ? ACT_EVAL : ACT_LOAD;
    it.point_index = IDX_W'($urandom_range(MAX_POINTS - 1));
    it.point_x = FCOORD_W'($urandom);
    it.point_y = FCOORD_W'($urandom);
    pick = $urandom_range(99);
    if (pick < 80) it.step_index = STEP_W'($urandom_range(cfg_steps));
    else if (pick < 90) it.step_index = cfg_steps;
    else it.step_index = STEP_W'($urandom);
    return it;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch: %s got %0d expected %0d", what, got, want);
    mismatches++;
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    if (idx == CFG_POINT_COUNT) cfg_points = val[PC_W-1:0];
    else cfg_steps = val[SD_W-1:0];
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic offer_item(bcpe_in_t it, bit fixed, bcpe_out_t fixed_res);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      in_data <= bcpe_in_t'($urandom);
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    if (it.action == ACT_EVAL) begin
      pending_points.push_back(fixed ? fixed_res : curve_point(it.step_index));
    end else begin
      store_x[it.point_index] = it.point_x;
      store_y[it.point_index] = it.point_y;
    end
    items_sent++;
  endtask

  // receiver: random stalls plus a long hold counted here
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req != 0) begin
        hold_left = hold_req;
        hold_req = 0;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_points.size() == 0) begin
        report_mismatch("curve point with none pending, x", out_data.curve_x, 0);
      end else begin
        due_point = pending_points.pop_front();
        if (out_data.curve_x !== due_point.curve_x)
          report_mismatch("curve_x", out_data.curve_x, due_point.curve_x);
        if (out_data.curve_y !== due_point.curve_y)
          report_mismatch("curve_y", out_data.curve_y, due_point.curve_y);
      end
      points_checked++;
    end
  end

  initial begin
    #3_600_000;
    $display("testbench: done, errors");
    $finish;
  end

  initial begin
    // every entry is loaded before the first evaluate
    plan.push_back(ld(0, 4095, 0));
    plan.push_back(ld(1, 0, 4095));
    plan.push_back(ld(2, 'hAAA, 'h555));
    plan.push_back(ld(3, 'h555, 'hAAA));
    for (int i = 4; i < MAX_POINTS; i++) plan.push_back(ld(i, i * 251, 4095 - i * 173));
    // reset settings: 4 points, 1000 steps
    plan.push_back(ev_fix(0, 65520, 0));
    plan.push_back(ev_fix(1000, 'h5550, 'hAAA0));
    plan.push_back(ev_fix(2047, 'h5550, 'hAAA0));
    plan.push_back(ev(500));
    plan.push_back(cf(CFG_POINT_COUNT, 16));
    plan.push_back(cf(CFG_SUBDIVISIONS, 1024));
    plan.push_back(ev_fix(1024, 60240, 24000));
    plan.push_back(ev(1));
    plan.push_back(ev(1023));
    // zero count acts as two points, zero steps as one
    plan.push_back(cf(CFG_POINT_COUNT, 0));
    plan.push_back(cf(CFG_SUBDIVISIONS, 0));
    plan.push_back(ev_fix(0, 65520, 0));
    plan.push_back(ev_fix(1, 0, 65520));

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        settle();
        write_reg(plan[i].reg_idx, plan[i].reg_val);
        settings_used++;
      end else begin
        offer_item(plan[i].item, plan[i].kind == ROW_ITEM_FIXED, plan[i].result);
      end
    end

    // long output hold while items keep coming
    settle();
    send_idle_pct = 0;
    stall_pct = 0;
    write_reg(CFG_POINT_COUNT, 4);
    write_reg(CFG_SUBDIVISIONS, 64);
    settings_used += 2;
    hold_req = 600;
    for (int i = 0; i < HOLD_ITEMS; i++) begin
      offer_item(random_item(), 1'b0, '0);
    end

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      int pc_list [RANDOM_PHASES];
      int sd_list [RANDOM_PHASES];
      int pc, sd;
      pc_list = '{2, 16, 7, 1, 4, 31, 10, 3};
      sd_list = '{1, 1024, 3, 0, 1000, 2047, 37, 500};
      pc = (ph >= 6) ? int'($urandom_range(2, MAX_POINTS)) : pc_list[ph];
      sd = (ph >= 6) ? int'($urandom_range(1, 1024)) : sd_list[ph];
      settle();
      write_reg(CFG_POINT_COUNT, {6'($urandom), 5'(pc)});
      write_reg(CFG_SUBDIVISIONS, CFG_DATA_W'(sd));
      settings_used += 2;
      case (ph % 4)
        0: begin
          send_idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          send_idle_pct = 57;
          stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct = 57;
        end
        default: begin
          send_idle_pct = 38;
          stall_pct = 38;
        end
      endcase
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        offer_item(random_item(), 1'b0, '0);
      end
    end

    settle();
    $display("sent %0d items (loads and evaluates), checked %0d curve points", items_sent,
             points_checked);
    $display("register writes covered %0d settings incl. out-of-range counts and steps",
             settings_used);
    if (mismatches == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
